>>> hdl/event_timestamp_filter_framer_assert.svh
`ifndef EVENT_TIMESTAMP_FILTER_FRAMER_ASSERT_SVH
`define EVENT_TIMESTAMP_FILTER_FRAMER_ASSERT_SVH

// implication checked on the same edge
`define ETF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication checked on the next edge
`define ETF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/etf_pkg.sv
package etf_pkg;

	localparam int TIME_BITS = 48;
	localparam int CFG_DATA_W = 48;
	localparam int CFG_IDX_W = 2;
	localparam int DEF_SENSOR_ROWS = 128;
	localparam int DEF_SENSOR_COLUMNS = 128;
	localparam int MID_DEPTH = 2;
	localparam int OUT_DEPTH = 2;

	localparam logic [TIME_BITS-1:0] WRAP_STEP = TIME_BITS'(64'd67108864);
	localparam logic [31:0] WRAP_FIELD_MASK = 32'hFC00_0000;
	localparam logic [31:0] WRAP_MARK = 32'h8800_0000;
	localparam logic [31:0] LOW_TIME_MASK = 32'h03FF_FFFF;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_INTERVAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RELIABILITY_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COORDINATE_OFFSET = 2'd2;

	localparam logic [47:0] RST_FRAME_INTERVAL = 48'd10000;
	localparam logic [47:0] RST_RELIABILITY_THRESHOLD = 48'd10000;
	localparam logic [3:0] RST_COORDINATE_OFFSET = 4'd0;

	typedef struct packed {
		logic [31:0] time_word;
		logic [6:0] row;
		logic [6:0] column;
		logic polarity;
		logic ignore;
	} in_item_t;

	typedef struct packed {
		logic event_kept;
		logic [7:0] out_row;
		logic [7:0] out_column;
		logic out_polarity;
		logic [47:0] event_time;
		logic frame_end;
	} out_item_t;

	typedef struct packed {
		logic [TIME_BITS-1:0] ts;
		logic [6:0] row;
		logic [6:0] column;
		logic polarity;
	} mid_item_t;

	typedef struct packed {
		logic [47:0] frame_interval;
		logic [47:0] reliability_threshold;
		logic [3:0] coordinate_offset;
	} cfg_t;

endpackage

>>> hdl/event_timestamp_filter_framer.sv
// address-event time filter and frame marker
// input side: a request is taken on a clock edge with push high and full low;
// time words with the wrap mark only advance the time offset, ignored or
// out-of-sensor events are dropped, the rest go through the pixel time store
// result side: while empty is low the oldest result sits on result and is
// taken on an edge with pop high; only passing events or frame ends appear
// path: front queue, then store read stage, then result queue
// throughput: one request per cycle while full stays low, set by the single
// read-modify-write of the pixel time store per event, with forwarding
// between adjacent events; a stalled pop fills the two-entry result queue,
// then the front queue, and then full rises; nothing is lost
// reset: after arst_n releases, the pixel time store is cleared one entry per
// cycle, all 2 * SENSOR_ROWS * SENSOR_COLUMNS entries (32768 by default),
// while full stays high; configuration writes are taken at any time
// configuration: write_en, write_index and write_data write one register per
// edge (0 frame interval, 1 reliability threshold, 2 coordinate offset)
`include "event_timestamp_filter_framer_assert.svh"

module event_timestamp_filter_framer
	import etf_pkg::*;
#(
	parameter int SENSOR_ROWS = DEF_SENSOR_ROWS,
	parameter int SENSOR_COLUMNS = DEF_SENSOR_COLUMNS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  in_item_t              item,
	input  logic                  pop,
	output logic                  empty,
	output out_item_t             result,
	input  logic                  write_en,
	input  logic [CFG_IDX_W-1:0]  write_index,
	input  logic [CFG_DATA_W-1:0] write_data
);

	cfg_t cfg_q;

	logic accept;
	logic mid_push;
	mid_item_t mid_wdata;
	mid_item_t mid_rdata;
	logic mid_empty;
	logic mid_full;
	logic mid_pop;
	logic res_push;
	out_item_t res_item;
	logic res_full;
	logic clearing;

	assign full = mid_full || clearing;
	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_interval <= RST_FRAME_INTERVAL;
			cfg_q.reliability_threshold <= RST_RELIABILITY_THRESHOLD;
			cfg_q.coordinate_offset <= RST_COORDINATE_OFFSET;
		end else if (write_en) begin
			unique case (write_index)
				CFG_FRAME_INTERVAL: cfg_q.frame_interval <= write_data;
				CFG_RELIABILITY_THRESHOLD: cfg_q.reliability_threshold <= write_data;
				CFG_COORDINATE_OFFSET: cfg_q.coordinate_offset <= write_data[3:0];
				default: ;
			endcase
		end
	end

	etf_front #(
		.SENSOR_ROWS(SENSOR_ROWS),
		.SENSOR_COLUMNS(SENSOR_COLUMNS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.item(item),
		.mid_push(mid_push),
		.mid_item(mid_wdata)
	);

	etf_fifo #(
		.W($bits(mid_item_t)),
		.DEPTH(MID_DEPTH)
	) u_mid_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr(mid_push),
		.wdata(mid_wdata),
		.rd(mid_pop),
		.rdata(mid_rdata),
		.empty(mid_empty),
		.full(mid_full)
	);

	etf_back #(
		.SENSOR_ROWS(SENSOR_ROWS),
		.SENSOR_COLUMNS(SENSOR_COLUMNS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.q_valid(!mid_empty),
		.q_item(mid_rdata),
		.q_pop(mid_pop),
		.res_full(res_full),
		.res_push(res_push),
		.res_item(res_item),
		.clearing(clearing)
	);

	etf_fifo #(
		.W($bits(out_item_t)),
		.DEPTH(OUT_DEPTH)
	) u_out_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr(res_push),
		.wdata(res_item),
		.rd(pop),
		.rdata(result),
		.empty(empty),
		.full(res_full)
	);

	`ETF_ASSERT_NOW(a_mid_no_overflow, mid_push, !mid_full, "front queue overflow")
	`ETF_ASSERT_NOW(a_res_no_overflow, res_push, !res_full, "result queue overflow")
	`ETF_ASSERT_NOW(a_result_meaningful, !empty, result.event_kept || result.frame_end,
		"result with neither kept event nor frame end")
	`ETF_ASSERT_NOW(a_clear_idle, $fell(clearing), mid_empty && empty,
		"requests present before store clear finished")

endmodule

>>> hdl/etf_fifo.sv
module etf_fifo #(
	parameter int W = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  logic [W-1:0] wdata,
	input  logic         rd,
	output logic [W-1:0] rdata,
	output logic         empty,
	output logic         full
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0] slot_q [DEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [CW-1:0] cnt_q;
	logic do_wr;
	logic do_rd;

	assign full = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = slot_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wp_q] <= wdata;
		end
	end

endmodule

>>> hdl/etf_front.sv
module etf_front
	import etf_pkg::*;
#(
	parameter int SENSOR_ROWS = DEF_SENSOR_ROWS,
	parameter int SENSOR_COLUMNS = DEF_SENSOR_COLUMNS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      accept,
	input  in_item_t  item,
	output logic      mid_push,
	output mid_item_t mid_item
);

	localparam logic [10:0] ROWS_L = 11'(SENSOR_ROWS);
	localparam logic [10:0] COLS_L = 11'(SENSOR_COLUMNS);

	logic [TIME_BITS-1:0] wrap_offset_q;
	logic is_wrap;
	logic in_range;

	assign is_wrap = ((item.time_word & WRAP_FIELD_MASK) == WRAP_MARK);
	assign in_range = ({4'b0, item.row} < ROWS_L) && ({4'b0, item.column} < COLS_L);

	assign mid_push = accept && !is_wrap && !item.ignore && in_range;
	assign mid_item.ts = TIME_BITS'(item.time_word & LOW_TIME_MASK) + wrap_offset_q;
	assign mid_item.row = item.row;
	assign mid_item.column = item.column;
	assign mid_item.polarity = item.polarity;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_offset_q <= '0;
		end else if (accept && is_wrap) begin
			wrap_offset_q <= wrap_offset_q + WRAP_STEP;
		end
	end

endmodule

>>> hdl/etf_back.sv
module etf_back
	import etf_pkg::*;
#(
	parameter int SENSOR_ROWS = DEF_SENSOR_ROWS,
	parameter int SENSOR_COLUMNS = DEF_SENSOR_COLUMNS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      q_valid,
	input  mid_item_t q_item,
	output logic      q_pop,
	input  logic      res_full,
	output logic      res_push,
	output out_item_t res_item,
	output logic      clearing
);

	localparam int PIXELS = SENSOR_ROWS * SENSOR_COLUMNS;
	localparam int MEM_DEPTH = 2 * PIXELS;
	localparam int AW = $clog2(MEM_DEPTH);

	logic [TIME_BITS-1:0] mem [MEM_DEPTH];

	logic clearing_q;
	logic [AW-1:0] clr_addr_q;

	logic s1_valid_q;
	logic fwd_s1;
	logic [TIME_BITS-1:0] fwd_ts_s1;
	logic [TIME_BITS-1:0] rdata_s1;
	logic [TIME_BITS-1:0] ts_s1;
	logic [6:0] row_s1;
	logic [6:0] col_s1;
	logic pol_s1;
	logic [AW-1:0] addr_s1;

	logic [TIME_BITS-1:0] last_frame_q;
	logic frame_nonempty_q;

	logic [AW-1:0] head_addr;
	logic take;
	logic adv;
	logic [TIME_BITS-1:0] prev;
	logic [TIME_BITS-1:0] pix_elapsed;
	logic [TIME_BITS-1:0] frame_elapsed;
	logic kept;
	logic boundary;
	logic fend;

	assign clearing = clearing_q;

	// pixel index, off store below on store
	assign head_addr = AW'(q_item.row) * AW'(SENSOR_COLUMNS) + AW'(q_item.column)
		+ (q_item.polarity ? AW'(PIXELS) : AW'(0));

	assign adv = s1_valid_q && !res_full;
	assign take = q_valid && !clearing_q && (!s1_valid_q || !res_full);
	assign q_pop = take;

	assign prev = fwd_s1 ? fwd_ts_s1 : rdata_s1;
	assign pix_elapsed = ts_s1 - prev;
	assign frame_elapsed = ts_s1 - last_frame_q;
	assign kept = (pix_elapsed <= cfg.reliability_threshold);
	assign boundary = (frame_elapsed > cfg.frame_interval);
	assign fend = boundary && (frame_nonempty_q || kept);

	assign res_push = adv && (kept || fend);
	assign res_item.event_kept = kept;
	assign res_item.out_row = kept ? 8'(row_s1) + 8'(cfg.coordinate_offset) : 8'd0;
	assign res_item.out_column = kept ? 8'(col_s1) + 8'(cfg.coordinate_offset) : 8'd0;
	assign res_item.out_polarity = kept ? pol_s1 : 1'b0;
	assign res_item.event_time = ts_s1;
	assign res_item.frame_end = fend;

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_addr_q] <= '0;
		end else if (adv) begin
			mem[addr_s1] <= ts_s1;
		end
		if (take) begin
			rdata_s1 <= mem[head_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ts_s1 <= q_item.ts;
			row_s1 <= q_item.row;
			col_s1 <= q_item.column;
			pol_s1 <= q_item.polarity;
			addr_s1 <= head_addr;
			fwd_ts_s1 <= ts_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
			s1_valid_q <= 1'b0;
			fwd_s1 <= 1'b0;
			last_frame_q <= '0;
			frame_nonempty_q <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == AW'(MEM_DEPTH - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			if (take) begin
				s1_valid_q <= 1'b1;
				// older request writes the same entry on this edge
				fwd_s1 <= adv && (addr_s1 == head_addr);
			end else if (adv) begin
				s1_valid_q <= 1'b0;
			end
			if (adv) begin
				if (boundary) begin
					last_frame_q <= ts_s1;
					frame_nonempty_q <= 1'b0;
				end else if (kept) begin
					frame_nonempty_q <= 1'b1;
				end
			end
		end
	end

endmodule

>>> verif/event_timestamp_filter_framer_tb.sv
module event_timestamp_filter_framer_tb;
	import etf_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned LONG_HOLD = 400;
	localparam int PIXELS = DEF_SENSOR_ROWS * DEF_SENSOR_COLUMNS;
	localparam logic [47:0] TIME_MAX = '1;

	typedef struct packed {
		out_item_t fields;
		logic [31:0] taken_at;
	} awaited_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	in_item_t item = '0;
	logic pop = 1'b0;
	logic empty;
	out_item_t result;
	logic write_en = 1'b0;
	logic [CFG_IDX_W-1:0] write_index = '0;
	logic [CFG_DATA_W-1:0] write_data = '0;

	// filter settings as the block should hold them
	logic [47:0] interval_cfg = RST_FRAME_INTERVAL;
	logic [47:0] threshold_cfg = RST_RELIABILITY_THRESHOLD;
	logic [3:0] offset_cfg = RST_COORDINATE_OFFSET;

	// filter state
	logic [47:0] time_offset = '0;
	logic [47:0] frame_mark_time = '0;
	logic frame_has_events = 1'b0;
	bit [47:0] on_times [PIXELS];
	bit [47:0] off_times [PIXELS];

	in_item_t event_queue [$];
	awaited_t awaited_results [$];

	int unsigned cycle_count = 0;
	int unsigned error_count = 0;
	int unsigned results_seen = 0;
	int unsigned hold_left = 0;
	logic long_hold_done = 1'b0;
	int unsigned sender_idle_pct = 0;
	int unsigned recv_idle_pct = 0;

	// event generator state
	int unsigned gen_low = 30000;
	logic [6:0] last_row = '0;
	logic [6:0] last_col = '0;
	logic last_pol = 1'b0;

	event_timestamp_filter_framer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.pop(pop),
		.empty(empty),
		.result(result),
		.write_en(write_en),
		.write_index(write_index),
		.write_data(write_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("event_timestamp_filter_framer_tb: done, errors");
			$finish;
		end
	end

	function automatic in_item_t make_item(logic [31:0] word, logic [6:0] row,
			logic [6:0] col, logic pol, logic ign);
		in_item_t it;
		it.time_word = word;
		it.row = row;
		it.column = col;
		it.polarity = pol;
		it.ignore = ign;
		return it;
	endfunction

	function automatic void add_event(in_item_t it);
		event_queue = {event_queue, it};
	endfunction

	function automatic void filter_event(in_item_t it);
		logic [47:0] ts;
		logic [47:0] prev;
		logic [47:0] age;
		logic [47:0] since_mark;
		logic kept;
		logic closes;
		int unsigned pix;
		awaited_t want;
		if ((it.time_word & WRAP_FIELD_MASK) == WRAP_MARK) begin
			time_offset = time_offset + WRAP_STEP;
			return;
		end
		ts = 48'(it.time_word & LOW_TIME_MASK) + time_offset;
		if (it.ignore)
			return;
		pix = 32'({it.row, it.column});
		if (it.polarity) begin
			prev = on_times[pix];
			on_times[pix] = ts;
		end else begin
			prev = off_times[pix];
			off_times[pix] = ts;
		end
		age = ts - prev;
		kept = age <= threshold_cfg;
		if (kept)
			frame_has_events = 1'b1;
		closes = 1'b0;
		since_mark = ts - frame_mark_time;
		if (since_mark > interval_cfg) begin
			frame_mark_time = ts;
			if (frame_has_events) begin
				closes = 1'b1;
				frame_has_events = 1'b0;
			end
		end
		if (!kept && !closes)
			return;
		want.fields.event_kept = kept;
		want.fields.out_row = kept ? {1'b0, it.row} + {4'b0, offset_cfg} : 8'd0;
		want.fields.out_column = kept ? {1'b0, it.column} + {4'b0, offset_cfg} : 8'd0;
		want.fields.out_polarity = kept ? it.polarity : 1'b0;
		want.fields.event_time = ts;
		want.fields.frame_end = closes;
		want.taken_at = cycle_count;
		awaited_results = {awaited_results, want};
	endfunction

	function automatic void check_result(out_item_t got);
		out_item_t want;
		awaited_t front;
		results_seen++;
		// an expectation queued at this very edge cannot be the one popped now
		if (awaited_results.size() == 0 || awaited_results[0].taken_at >= cycle_count) begin
			error_count++;
			if (error_count <= 10)
				$display("unexpected result: kept %b row %0d col %0d pol %b time %h end %b",
					got.event_kept, got.out_row, got.out_column, got.out_polarity,
					got.event_time, got.frame_end);
			return;
		end
		front = awaited_results.pop_front();
		want = front.fields;
		if (got.event_kept !== want.event_kept || got.out_row !== want.out_row ||
				got.out_column !== want.out_column ||
				got.out_polarity !== want.out_polarity ||
				got.event_time !== want.event_time || got.frame_end !== want.frame_end) begin
			error_count++;
			if (error_count <= 10) begin
				$display("mismatch expected: kept %b row %0d col %0d pol %b time %h end %b",
					want.event_kept, want.out_row, want.out_column, want.out_polarity,
					want.event_time, want.frame_end);
				$display("         actual:   kept %b row %0d col %0d pol %b time %h end %b",
					got.event_kept, got.out_row, got.out_column, got.out_polarity,
					got.event_time, got.frame_end);
			end
		end
	endfunction

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full)
				filter_event(item);
			if (!push || !full) begin
				if (event_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					item <= event_queue.pop_front();
					push <= 1'b1;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty)
				check_result(result);
			if (!long_hold_done && results_seen >= 60 && event_queue.size() > 40) begin
				hold_left = LONG_HOLD;
				long_hold_done = 1'b1;
			end
			if (hold_left != 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= $urandom_range(99) >= recv_idle_pct;
			end
		end
	end

	task automatic apply_settings(logic [47:0] interval, logic [47:0] threshold,
			logic [3:0] offset);
		@(posedge clk);
		write_en <= 1'b1;
		write_index <= CFG_FRAME_INTERVAL;
		write_data <= interval;
		@(posedge clk);
		write_index <= CFG_RELIABILITY_THRESHOLD;
		write_data <= threshold;
		@(posedge clk);
		write_index <= CFG_COORDINATE_OFFSET;
		write_data <= 48'(offset);
		@(posedge clk);
		write_en <= 1'b0;
		interval_cfg = interval;
		threshold_cfg = threshold;
		offset_cfg = offset;
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (event_queue.size() != 0 || push || awaited_results.size() != 0);
		// dropped events give no result but may still be in flight
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic queue_random(int count, int unsigned step_max);
		int unsigned pick;
		int unsigned low;
		logic [5:0] top;
		logic [6:0] row;
		logic [6:0] col;
		logic pol;
		for (int n = 0; n < count; n++) begin
			top = 6'($urandom_range(63));
			if (top == WRAP_MARK[31:26])
				top = ~top;
			pick = $urandom_range(99);
			if (pick < 5) begin
				add_event(in_item_t'({$urandom(), 16'($urandom())}));
				continue;
			end
			pick = $urandom_range(99);
			if (pick < 3) begin
				gen_low += $urandom_range(1 << 20, 1 << 25);
			end else if (pick >= 6) begin
				gen_low += $urandom_range(step_max);
			end
			if (gen_low >= (1 << 26)) begin
				gen_low -= 1 << 26;
				add_event(make_item(WRAP_MARK | ($urandom() & LOW_TIME_MASK),
					7'($urandom()), 7'($urandom()), 1'($urandom()), 1'($urandom())));
			end
			low = gen_low;
			// time running backward
			if (pick >= 3 && pick < 6 && gen_low >= 3000)
				low = gen_low - $urandom_range(3000);
			pick = $urandom_range(99);
			if (pick < 20) begin
				row = last_row;
				col = last_col;
				pol = last_pol;
			end else if (pick < 80) begin
				row = $urandom_range(1) ? 7'd127 : 7'd0;
				col = $urandom_range(1) ? 7'd127 : 7'd0;
				pol = 1'($urandom());
			end else begin
				row = 7'($urandom());
				col = 7'($urandom());
				pol = 1'($urandom());
			end
			add_event(make_item({top, 26'(low)}, row, col, pol,
				$urandom_range(99) < 8));
			last_row = row;
			last_col = col;
			last_pol = pol;
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		sender_idle_pct = 19;
		recv_idle_pct = 66;
		apply_settings(48'd5000, 48'd2000, 4'd15);
		add_event(make_item(32'd100, 7'd0, 7'd0, 1'b0, 1'b0));
		add_event(make_item(32'd1500, 7'd127, 7'd127, 1'b1, 1'b0));
		// age exactly at threshold, then one past it with a frame close
		add_event(make_item(32'd3500, 7'd127, 7'd127, 1'b1, 1'b0));
		add_event(make_item(32'd5501, 7'd127, 7'd127, 1'b1, 1'b0));
		add_event(make_item(32'd6000, 7'd0, 7'd0, 1'b0, 1'b0));
		// boundary on an empty frame
		add_event(make_item(32'd10600, 7'd1, 7'd2, 1'b1, 1'b0));
		add_event(make_item(32'd12000, 7'd1, 7'd2, 1'b1, 1'b0));
		add_event(make_item(32'd17000, 7'd1, 7'd2, 1'b0, 1'b0));
		add_event(make_item(32'd17100, 7'd5, 7'd5, 1'b0, 1'b0));
		add_event(make_item(32'd18000, 7'd5, 7'd5, 1'b0, 1'b0));
		add_event(make_item(32'd22100, 7'd5, 7'd5, 1'b0, 1'b0));
		// passing event closes its own frame
		add_event(make_item(32'd25500, 7'd9, 7'd9, 1'b1, 1'b0));
		add_event(make_item(32'd27200, 7'd9, 7'd9, 1'b1, 1'b0));
		// ignored event must not touch the pixel store
		add_event(make_item(32'd27300, 7'd9, 7'd9, 1'b1, 1'b1));
		add_event(make_item(32'd29250, 7'd9, 7'd9, 1'b1, 1'b0));
		// wrap word with junk address and ignore set
		add_event(make_item(WRAP_MARK | LOW_TIME_MASK, 7'd127, 7'd127,
			1'b1, 1'b1));
		add_event(make_item(32'd29300, 7'd9, 7'd9, 1'b1, 1'b0));
		add_event(make_item(32'd30000, 7'd9, 7'd9, 1'b1, 1'b0));
		// stored time later than event time
		add_event(make_item(32'd29000, 7'd9, 7'd9, 1'b1, 1'b0));
		add_event(make_item(32'hFFFF_FFFF, 7'd127, 7'd0, 1'b1, 1'b0));
		add_event(make_item(32'h77FF_FFFF, 7'd127, 7'd0, 1'b1, 1'b0));
		add_event(make_item(32'h87FF_FF00, 7'd127, 7'd0, 1'b1, 1'b0));
		queue_random(130, 600);
		wait_drained();

		apply_settings(48'd0, TIME_MAX, 4'd0);
		queue_random(70, 600);
		wait_drained();
		queue_random(70, 600);
		wait_drained();

		sender_idle_pct = 66;
		recv_idle_pct = 19;
		apply_settings(TIME_MAX, 48'd0, 4'd7);
		queue_random(140, 1);
		wait_drained();

		sender_idle_pct = 0;
		recv_idle_pct = 0;
		apply_settings(48'd20000, 48'd10000, 4'd8);
		queue_random(140, 1500);
		wait_drained();

		if (error_count == 0) begin
			$display("event_timestamp_filter_framer_tb: done, clean");
		end else begin
			$display("event_timestamp_filter_framer_tb: done, errors");
		end
		$finish;
	end

endmodule
